// ===== hdl/pcs_pkg.sv =====
// Package for the PUCT child selector: constants and the shared request type.
`timescale 1ns / 1ps
package pcs_pkg;
    localparam int MAX_CHILDREN_DEF = 256;
    localparam logic [15:0] GAIN_RESET = 16'd4096;

    typedef struct packed {
        logic        present;
        logic        first;
        logic        last;
        logic [7:0]  index;
        logic [15:0] prior;
        logic [19:0] visits;
        logic [15:0] mean_value;
        logic [19:0] parent_visits;
    } pcs_req_t;
endpackage

// ===== hdl/pcs_front.sv =====
// Front end: accepts requests, tracks position within a run, queues them for the back end.
`timescale 1ns / 1ps
module pcs_front
    import pcs_pkg::*;
#(
    parameter int MAX_CHILDREN = MAX_CHILDREN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        child_present,
    input  logic [15:0] prior,
    input  logic [19:0] visits,
    input  logic [15:0] mean_value,
    input  logic [19:0] parent_visits,
    input  logic        last,
    output logic        q_valid,
    input  logic        q_take,
    output pcs_req_t    q_data
);
    localparam logic [7:0] POS_MAX = 8'(MAX_CHILDREN - 1);
    pcs_req_t   slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_reg, rd_reg;
    logic [7:0] pos_reg;
    logic       acc;
    pcs_req_t   item;

    assign in_stall = (cnt_reg == 2'd2);
    assign acc      = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = slot_reg[rd_reg];

    always_comb
    begin
        item.present       = child_present;
        item.first         = (pos_reg == 8'd0);
        item.last          = last;
        item.index         = pos_reg;
        item.prior         = prior;
        item.visits        = visits;
        item.mean_value    = mean_value;
        item.parent_visits = parent_visits;
        cnt_next = cnt_reg + 2'(acc) - 2'(q_take && q_valid);
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            slot_reg[wr_reg] <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            pos_reg <= 8'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (acc)
            begin
                wr_reg <= !wr_reg;
                if (last)
                    pos_reg <= 8'd0;
                else if (pos_reg < POS_MAX)
                    pos_reg <= pos_reg + 8'd1;
            end
            if (q_take && q_valid)
                rd_reg <= !rd_reg;
        end
    end
endmodule

// ===== hdl/pcs_back.sv =====
// Back end: square root, product, serial divide, compare and result register.
`timescale 1ns / 1ps
module pcs_back
    import pcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] gain,
    input  logic        q_valid,
    output logic        q_take,
    input  pcs_req_t    q_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  best_index,
    output logic [31:0] best_score,
    output logic        found
);
    localparam logic [2:0] S_IDLE = 3'd0, S_SQRT = 3'd1, S_MUL1 = 3'd2,
                           S_MUL2 = 3'd3, S_DIV = 3'd4, S_CMP = 3'd5;

    logic [2:0]  st_reg;
    pcs_req_t    it_reg;
    logic [37:0] rx_reg;      // sqrt remainder
    logic [37:0] rres_reg;
    logic [37:0] rbit_reg;
    logic [19:0] root_reg;
    logic [31:0] cp_reg;
    logic [50:0] num_reg;     // quotient shifts in from the bottom
    logic [40:0] den_reg;
    logic [51:0] rem_reg;
    logic [5:0]  dcnt_reg;
    logic signed [31:0] bs_reg;
    logic [7:0]  bi_reg;
    logic        any_reg;

    logic [51:0] rem_sh;
    logic signed [31:0] score;
    logic [37:0] sum;
    logic        emit;

    assign q_take = (st_reg == S_IDLE) && q_valid;
    assign rem_sh = {rem_reg[50:0], num_reg[50]};
    assign sum    = rres_reg + rbit_reg;
    assign score  = signed'(num_reg[31:0]) + ((it_reg.visits != 20'd0)
                    ? 32'(signed'({it_reg.mean_value, 1'b0})) : 32'sd0);
    // The last child of a run loads the result register once it is free.
    assign emit   = (st_reg == S_CMP) && it_reg.last && (!out_valid || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            out_valid <= 1'b0;
            bs_reg    <= 32'sh8000_0000;
            bi_reg    <= 8'd0;
            any_reg   <= 1'b0;
            root_reg  <= 20'd0;
        end
        else
        begin
            if (emit)
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        it_reg   <= q_data;
                        rx_reg   <= {2'b0, 20'(q_data.parent_visits) + 20'd0, 16'd0}
                                    + {21'd0, 1'b1, 16'd0};
                        rres_reg <= 38'd0;
                        rbit_reg <= 38'd1 << 36;
                        st_reg   <= q_data.first ? S_SQRT : S_MUL1;
                    end
                end
                S_SQRT:
                begin
                    if (rx_reg >= sum)
                    begin
                        rx_reg   <= rx_reg - sum;
                        rres_reg <= (rres_reg >> 1) + rbit_reg;
                    end
                    else
                        rres_reg <= rres_reg >> 1;
                    rbit_reg <= rbit_reg >> 2;
                    if (rbit_reg[0])
                    begin
                        root_reg <= (rx_reg >= sum) ? 20'((rres_reg >> 1) + rbit_reg)
                                                    : 20'(rres_reg >> 1);
                        st_reg <= S_MUL1;
                    end
                end
                S_MUL1:
                begin
                    cp_reg <= 32'(gain) * 32'(it_reg.prior);
                    st_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    num_reg  <= 51'(cp_reg) * 51'(root_reg);
                    den_reg  <= {21'(it_reg.visits) + 21'd1, 20'd0};
                    rem_reg  <= 52'd0;
                    dcnt_reg <= 6'd0;
                    st_reg   <= it_reg.present ? S_DIV : S_CMP;
                end
                S_DIV:
                begin
                    if (rem_sh >= 52'(den_reg))
                    begin
                        rem_reg <= rem_sh - 52'(den_reg);
                        num_reg <= {num_reg[49:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        num_reg <= {num_reg[49:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (dcnt_reg == 6'd50)
                        st_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (!it_reg.last || !out_valid || !out_stall)
                    begin
                        logic signed [31:0] nbs;
                        logic [7:0] nbi;
                        logic nany;
                        nbs  = bs_reg;
                        nbi  = bi_reg;
                        nany = any_reg;
                        if (it_reg.present)
                        begin
                            nany = 1'b1;
                            if (score > bs_reg)
                            begin
                                nbs = score;
                                nbi = it_reg.index;
                            end
                        end
                        if (it_reg.last)
                        begin
                            best_index <= nany ? nbi : 8'd0;
                            best_score <= nany ? 32'(nbs) : 32'd0;
                            found      <= nany;
                            bs_reg     <= 32'sh8000_0000;
                            bi_reg     <= 8'd0;
                            any_reg    <= 1'b0;
                        end
                        else
                        begin
                            bs_reg  <= nbs;
                            bi_reg  <= nbi;
                            any_reg <= nany;
                        end
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hdl/puct_child_select_top.sv =====
// Top level of the PUCT child selector.
`timescale 1ns / 1ps
// Usage: children of one node arrive as requests on the input channel
// (in_valid / in_stall), one per child, with last marking the final one.
// exploration_gain is written through cfg_we / cfg_data while idle.
// A front end numbers the requests and holds up to two in a queue; a back
// end takes each child from the queue and scores it: a bit-serial square
// root of the parent count plus one on the first child, the multiply
// steps, a restoring divide and a compare. An absent child still takes
// the multiply steps but skips the divide.
// The run's last child produces one result on the output channel
// (out_valid / out_stall) in the cycle after its compare. While the receiver
// stalls the result holds; the back end keeps working until the next last
// child, and the queue absorbs two more requests before in_stall rises.
// Reset clears the queue, the run state and the output valid, and sets the
// gain to 1.0 in Q4.12.
module puct_child_select_top
    import pcs_pkg::*;
#(
    parameter int MAX_CHILDREN = MAX_CHILDREN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        child_present,
    input  logic [15:0] prior,
    input  logic [19:0] visits,
    input  logic [15:0] mean_value,
    input  logic [19:0] parent_visits,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  best_index,
    output logic [31:0] best_score,
    output logic        found
);
    logic [15:0] gain_reg;
    logic        q_valid, q_take;
    pcs_req_t    q_data;

    // Configuration register; the user must write it only between runs, the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_reg <= GAIN_RESET;
        else if (cfg_we)
            gain_reg <= cfg_data;
    end

    pcs_front #(.MAX_CHILDREN(MAX_CHILDREN)) u_front (
        .clk, .rst_n, .in_valid, .in_stall, .child_present, .prior, .visits,
        .mean_value, .parent_visits, .last, .q_valid, .q_take, .q_data
    );

    pcs_back u_back (
        .clk, .rst_n, .gain(gain_reg), .q_valid, .q_take, .q_data,
        .out_valid, .out_stall, .best_index, .best_score, .found
    );
endmodule

// ===== test/tb_puct_child_select_top.sv =====
// Testbench for the PUCT child selector: directed table, gain extremes, then random runs.
`timescale 1ns / 1ps
module tb_puct_child_select_top;
    import pcs_pkg::*;

    // One child request as driven onto the input channel.
    typedef struct {
        logic        present;
        logic [15:0] prior;
        logic [19:0] visits;
        logic [15:0] mean_value;
        logic [19:0] parent_visits;
        logic        last;
    } child_t;

    // One selection result.
    typedef struct {
        logic [7:0]  index;
        logic [31:0] score;
        logic        found;
    } pick_t;

    // A directed row: the child, and where it closes a run, a typed result.
    typedef struct {
        child_t c;
        logic   typed;
        pick_t  want;
    } row_t;

    localparam int LIMIT_CYCLES = 4000000;
    localparam int SETTLE_CYCLES = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        child_present = 1'b0;
    logic [15:0] prior = '0;
    logic [19:0] visits = '0;
    logic [15:0] mean_value = '0;
    logic [19:0] parent_visits = '0;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  best_index;
    logic [31:0] best_score;
    logic        found;

    puct_child_select_top dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .child_present(child_present),
        .prior(prior), .visits(visits), .mean_value(mean_value),
        .parent_visits(parent_visits), .last(last), .out_valid(out_valid),
        .out_stall(out_stall), .best_index(best_index), .best_score(best_score),
        .found(found)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predictor state: the gain and the state of the run in progress.
    logic [15:0] gain_q;
    logic [7:0]  run_pos;
    logic signed [31:0] run_best;
    logic [7:0]  run_best_idx;
    logic        run_any;
    logic [19:0] run_root;

    pick_t picks_pending[$];
    int    errors = 0;
    int    mismatches = 0;
    int    picks_seen = 0;
    int    children_sent = 0;
    int    cycle_count = 0;
    int    send_idle_pct = 0;
    int    stall_pct = 0;

    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    task automatic clear_run();
        run_pos = 0;
        run_best = 32'sh8000_0000;
        run_best_idx = 0;
        run_any = 1'b0;
        run_root = 0;
    endtask

    // Scores one accepted child and, on the last child, queues the selection.
    task automatic score_child(input child_t c);
        logic [63:0] num;
        logic [63:0] u;
        logic signed [31:0] sc;
        pick_t p;
        if (run_pos == 0)
            run_root = 20'(isqrt(({44'd0, c.parent_visits} + 64'd1) << 16));
        if (c.present)
        begin
            num = 64'(gain_q) * 64'(c.prior) * 64'(run_root);
            u = num / ((64'(c.visits) + 64'd1) << 20);
            sc = u[31:0];
            if (c.visits != 0)
                sc = sc + 32'($signed(c.mean_value)) * 2;
            if (sc > run_best)
            begin
                run_best = sc;
                run_best_idx = run_pos;
            end
            run_any = 1'b1;
        end
        if (run_pos < 8'd255)
            run_pos++;
        if (c.last)
        begin
            p.index = run_any ? run_best_idx : 8'd0;
            p.score = run_any ? run_best : 32'd0;
            p.found = run_any;
            picks_pending.push_back(p);
            clear_run();
        end
    endtask

    // Drives one child at the falling edge and waits until it is accepted.
    task automatic send_child(input child_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        child_present <= c.present;
        prior <= c.prior;
        visits <= c.visits;
        mean_value <= c.mean_value;
        parent_visits <= c.parent_visits;
        last <= c.last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        score_child(c);
        children_sent++;
        @(negedge clk);
    endtask

    // Waits for every expected result, then lets the back end drain.
    task automatic drain();
        in_valid <= 1'b0;
        while (picks_pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_gain(input logic [15:0] g);
        cfg_we <= 1'b1;
        cfg_data <= g;
        @(negedge clk);
        cfg_we <= 1'b0;
        gain_q = g;
    endtask

    function automatic child_t rand_child(input logic lst);
        child_t c;
        c.present = ($urandom_range(9) != 0);
        c.prior = 16'($urandom);
        case ($urandom_range(3))
            0: c.visits = 20'd0;
            1: c.visits = 20'($urandom_range(15));
            2: c.visits = 20'($urandom_range(1023));
            default: c.visits = 20'($urandom);
        endcase
        c.mean_value = 16'($urandom);
        c.parent_visits = $urandom_range(1) ? 20'($urandom) : 20'($urandom_range(4095));
        c.last = lst;
        return c;
    endfunction

    // Output side: random stalls, and comparison against the oldest expectation.
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n && out_valid && !out_stall)
        begin
            pick_t w;
            picks_seen++;
            if (picks_pending.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("Unexpected result idx=%0d score=%h found=%0d",
                             best_index, best_score, found);
            end
            else
            begin
                w = picks_pending.pop_front();
                if (w.index !== best_index || w.score !== best_score
                    || w.found !== found)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("Mismatch: want idx=%0d score=%h found=%0d, got %0d %h %0d",
                                 w.index, w.score, w.found, best_index, best_score, found);
                end
            end
        end
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timeout with %0d results outstanding", picks_pending.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    row_t rows[$];

    function automatic row_t mk(input logic pr, input logic [15:0] p, input logic [19:0] n,
                                input logic [15:0] q, input logic [19:0] np, input logic l,
                                input logic ty, input logic [7:0] wi,
                                input logic [31:0] ws, input logic wf);
        row_t r;
        r.c = '{pr, p, n, q, np, l};
        r.typed = ty;
        r.want = '{wi, ws, wf};
        return r;
    endfunction

    initial
    begin
        child_t c;
        int n_runs;
        int len;
        gain_q = GAIN_RESET;
        clear_run();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed runs at the reset gain.
        rows.push_back(mk(0, 0, 0, 0, 0, 1, 1, 0, 0, 0));            // no child at all
        rows.push_back(mk(1, 0, 0, 0, 0, 1, 1, 0, 0, 1));            // zero prior scores 0
        rows.push_back(mk(1, 16'hFFFF, 20'hFFFFF, 16'h8000, 20'hFFFFF, 0, 0, 0, 0, 0));
        rows.push_back(mk(1, 16'hFFFF, 0, 16'h7FFF, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 16'hFFFF, 0, 16'h7FFF, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(1, 16'hFFFF, 0, 16'h7FFF, 0, 1, 0, 0, 0, 0)); // tie keeps first
        rows.push_back(mk(1, 16'h8000, 1, 16'h8000, 20'hFFFFF, 0, 0, 0, 0, 0));
        rows.push_back(mk(1, 16'h8000, 1, 16'h7FFF, 0, 1, 0, 0, 0, 0));
        rows.push_back(mk(0, 16'hFFFF, 5, 16'h1234, 20'hFFFFF, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 16'hFFFF, 5, 16'h1234, 7, 1, 1, 0, 0, 0)); // all absent
        foreach (rows[i])
        begin
            send_child(rows[i].c);
            if (rows[i].typed)
                picks_pending[$] = rows[i].want;
        end
        drain();

        // Gain extremes, with a long run so the position saturates.
        write_gain(16'hFFFF);
        for (int i = 0; i < 300; i++)
        begin
            c = rand_child(i == 299);
            c.present = (i == 0 || i > 290);
            send_child(c);
        end
        drain();
        write_gain(16'h0000);
        for (int i = 0; i < 4; i++)
            send_child(rand_child(i == 3));
        drain();

        // Random runs over several gains and idling phases.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 86; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 86; end
                3: begin send_idle_pct = 22; stall_pct = 22; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            write_gain(ph == 4 ? 16'hFFFF : 16'($urandom));
            n_runs = 0;
            while (n_runs < 15)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                    send_child(rand_child(k == len - 1));
                n_runs++;
            end
            drain();
        end

        stall_pct = 0;
        drain();
        $display("Sent %0d children, checked %0d selections over several gains and idling phases.",
                 children_sent, picks_seen);
        if (errors == 0 && picks_pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
